@@ hw/rtl/tlwsu_pkg.sv @@
// ----------------------------------------------------------------------------
// tlwsu_pkg
// Shared types and constants for the list-word splitter with sweep unwrap.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package tlwsu_pkg;

  // Register index map of the configuration port
  typedef enum logic [2:0] {
    CFG_FILTER_ON   = 3'd0,
    CFG_SEL_CHANNEL = 3'd1,
    CFG_TIME_LOW    = 3'd2,
    CFG_TIME_BITS   = 3'd3,
    CFG_SWEEP_LOW   = 3'd4,
    CFG_SWEEP_BITS  = 3'd5,
    CFG_TAG_LOW     = 3'd6,
    CFG_LOST_BIT    = 3'd7
  } cfg_idx_e;

  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 6;

  // Channel numbering
  localparam logic [2:0] ChanMin   = 3'd1;
  localparam logic [2:0] ChanStart = 3'd6;

  // Widest sweep counter
  localparam logic [4:0] SweepMaxBits = 5'd16;

  // Reset values of the configuration registers
  localparam logic       RstFilterOn  = 1'b1;
  localparam logic [2:0] RstSelChan   = 3'd1;
  localparam logic [5:0] RstTimeLow   = 6'd4;
  localparam logic [5:0] RstTimeBits  = 6'd36;
  localparam logic [5:0] RstSweepLow  = 6'd40;
  localparam logic [4:0] RstSweepBits = 5'd7;
  localparam logic [5:0] RstTagLow    = 6'd48;
  localparam logic [5:0] RstLostBit   = 6'd47;

  // Configuration as seen by the front and back parts
  typedef struct packed {
    logic       filter_on;
    logic [2:0] sel_channel;
    logic [5:0] time_low;
    logic [5:0] time_bits;
    logic [5:0] sweep_low;
    logic [4:0] sweep_bits;
    logic [5:0] tag_low;
    logic [5:0] lost_bit;
  } cfg_t;

  // One classified hit, passed from front to back through the queue
  typedef struct packed {
    logic [2:0]  channel;
    logic        edge_bit;
    logic [47:0] time_val;
    logic [15:0] sweep;
    logic        tag;
    logic        lost;
  } hit_t;

  localparam int unsigned QueueDepth = 2;

endpackage : tlwsu_pkg

`default_nettype wire

@@ hw/rtl/tdc_list_word_sweep_unwrap.sv @@
// Path: a kept word is written into the queue, then into the output register.
// Throughput: one word per cycle while the output is not stalled; the back part
//   takes one hit a cycle from the two-entry queue while its output can move.
// Words that give no hit take no queue slot and produce no output beat.
// Reset (async, active low) restores the register defaults and clears the
//   sweep history, global sweep and event count; no clearing pass.
// ----------------------------------------------------------------------------
// tdc_list_word_sweep_unwrap
// Splits 64-bit list-mode digitizer words into hit fields and extends the
// wrapped sweep counter to a global sweep number with event counting.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tdc_list_word_sweep_unwrap (
  input  wire                                clk_i,
  input  wire                                rst_ni,
  // configuration write port
  input  wire                                cfg_we_i,
  input  wire [tlwsu_pkg::CfgIdxW-1:0]       cfg_idx_i,
  input  wire [tlwsu_pkg::CfgDataW-1:0]      cfg_wdata_i,
  // input words
  input  wire                                in_valid_i,
  output logic                               in_ready_o,
  input  wire [63:0]                         raw_word_i,
  // output hits
  output logic                               out_valid_o,
  input  wire                                out_ready_i,
  output logic [2:0]                         hit_channel_o,
  output logic                               hit_edge_o,
  output logic [47:0]                        time_value_o,
  output logic [15:0]                        sweep_local_o,
  output logic signed [47:0]                 global_sweep_o,
  output logic                               hit_tag_o,
  output logic                               hit_lost_o,
  output logic                               new_event_o,
  output logic [31:0]                        event_number_o
);
  import tlwsu_pkg::*;

  cfg_t cfg_q;
  logic q_full, q_valid, push, pop;
  hit_t hit_in, hit_out;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.filter_on   <= RstFilterOn;
      cfg_q.sel_channel <= RstSelChan;
      cfg_q.time_low    <= RstTimeLow;
      cfg_q.time_bits   <= RstTimeBits;
      cfg_q.sweep_low   <= RstSweepLow;
      cfg_q.sweep_bits  <= RstSweepBits;
      cfg_q.tag_low     <= RstTagLow;
      cfg_q.lost_bit    <= RstLostBit;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_FILTER_ON:   cfg_q.filter_on   <= cfg_wdata_i[0];
        CFG_SEL_CHANNEL: cfg_q.sel_channel <= cfg_wdata_i[2:0];
        CFG_TIME_LOW:    cfg_q.time_low    <= cfg_wdata_i;
        CFG_TIME_BITS:   cfg_q.time_bits   <= cfg_wdata_i;
        CFG_SWEEP_LOW:   cfg_q.sweep_low   <= cfg_wdata_i;
        CFG_SWEEP_BITS:  cfg_q.sweep_bits  <= cfg_wdata_i[4:0];
        CFG_TAG_LOW:     cfg_q.tag_low     <= cfg_wdata_i;
        CFG_LOST_BIT:    cfg_q.lost_bit    <= cfg_wdata_i;
        default: begin
        end
      endcase
    end
  end

  // Front: accept and classify
  tlwsu_front u_front (
    .cfg_i      (cfg_q),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .raw_word_i (raw_word_i),
    .q_full_i   (q_full),
    .push_o     (push),
    .hit_o      (hit_in)
  );

  // Queue between the two parts
  tlwsu_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i (hit_in),
    .full_o  (q_full),
    .pop_i   (pop),
    .valid_o (q_valid),
    .rdata_o (hit_out)
  );

  // Back: unwrap and output register
  tlwsu_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .sweep_bits_i   (cfg_q.sweep_bits),
    .q_valid_i      (q_valid),
    .q_data_i       (hit_out),
    .pop_o          (pop),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .hit_channel_o  (hit_channel_o),
    .hit_edge_o     (hit_edge_o),
    .time_value_o   (time_value_o),
    .sweep_local_o  (sweep_local_o),
    .global_sweep_o (global_sweep_o),
    .hit_tag_o      (hit_tag_o),
    .hit_lost_o     (hit_lost_o),
    .new_event_o    (new_event_o),
    .event_number_o (event_number_o)
  );

endmodule : tdc_list_word_sweep_unwrap

`default_nettype wire

@@ hw/rtl/tlwsu_front.sv @@
// ----------------------------------------------------------------------------
// tlwsu_front
// Accepts raw list-mode words, drops the ones that give no hit and splits
// the rest into fields at the configured bit positions.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tlwsu_front (
  input  wire tlwsu_pkg::cfg_t cfg_i,
  input  wire                  in_valid_i,
  output logic                 in_ready_o,
  input  wire [63:0]           raw_word_i,
  input  wire                  q_full_i,
  output logic                 push_o,
  output tlwsu_pkg::hit_t      hit_o
);
  import tlwsu_pkg::*;

  logic [2:0]  chan;
  logic        keep;
  logic [63:0] time_sh;
  logic [63:0] sweep_sh;
  logic [48:0] time_mask;
  logic [16:0] sweep_mask;
  logic [47:0] time_val;

  // Classify: zero words, bad channels and filtered channels are dropped
  always_comb begin
    chan = raw_word_i[2:0];
    keep = (raw_word_i != 64'd0) && (chan >= ChanMin) && (chan <= ChanStart);
    if (cfg_i.filter_on && (chan != cfg_i.sel_channel) && (chan != ChanStart)) begin
      keep = 1'b0;
    end
  end

  // Field extraction; widths past the field limit saturate to all ones
  always_comb begin
    time_sh    = raw_word_i >> cfg_i.time_low;
    sweep_sh   = raw_word_i >> cfg_i.sweep_low;
    time_mask  = ~({49{1'b1}} << cfg_i.time_bits);
    sweep_mask = ~({17{1'b1}} << cfg_i.sweep_bits);
    time_val   = time_sh[47:0] & time_mask[47:0];

    hit_o.channel  = chan;
    hit_o.edge_bit = raw_word_i[3];
    hit_o.time_val = time_val;
    hit_o.sweep    = sweep_sh[15:0] & sweep_mask[15:0];
    // tag flips when the time field is zero
    hit_o.tag      = raw_word_i[cfg_i.tag_low] ^ (time_val == 48'd0);
    hit_o.lost     = raw_word_i[cfg_i.lost_bit];
  end

  // Words that give no hit are taken and dropped without using a slot
  assign in_ready_o = !q_full_i;
  assign push_o     = in_valid_i && !q_full_i && keep;

endmodule : tlwsu_front

`default_nettype wire

@@ hw/rtl/tlwsu_queue.sv @@
// ----------------------------------------------------------------------------
// tlwsu_queue
// Short hit queue between the front and back parts.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tlwsu_queue (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  push_i,
  input  wire tlwsu_pkg::hit_t wdata_i,
  output logic                 full_o,
  input  wire                  pop_i,
  output logic                 valid_o,
  output tlwsu_pkg::hit_t      rdata_o
);
  import tlwsu_pkg::*;

  localparam int unsigned PtrW = $clog2(QueueDepth);
  localparam int unsigned CntW = $clog2(QueueDepth + 1);

  hit_t            slot_q [QueueDepth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;

  assign full_o  = (cnt_q == CntW'(QueueDepth));
  assign valid_o = (cnt_q != '0);
  assign rdata_o = slot_q[rd_ptr_q];

  // Pointer and fill count update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Slot storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= wdata_i;
    end
  end

endmodule : tlwsu_queue

`default_nettype wire

@@ hw/rtl/tlwsu_back.sv @@
// ----------------------------------------------------------------------------
// tlwsu_back
// Sweep unwrap and event counting; holds the output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tlwsu_back (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire [4:0]            sweep_bits_i,
  input  wire                  q_valid_i,
  input  wire tlwsu_pkg::hit_t q_data_i,
  output logic                 pop_o,
  output logic                 out_valid_o,
  input  wire                  out_ready_i,
  output logic [2:0]           hit_channel_o,
  output logic                 hit_edge_o,
  output logic [47:0]          time_value_o,
  output logic [15:0]          sweep_local_o,
  output logic signed [47:0]   global_sweep_o,
  output logic                 hit_tag_o,
  output logic                 hit_lost_o,
  output logic                 new_event_o,
  output logic [31:0]          event_number_o
);
  import tlwsu_pkg::*;

  // Unwrap state
  logic [15:0] last_q;
  logic        have_q;
  logic [47:0] gsweep_q, gsweep_d;
  logic [31:0] evcnt_q, evcnt_d;
  logic        out_valid_q;

  logic        take;
  logic        is_new;
  logic [4:0]  sb;
  logic [47:0] full48;
  logic [16:0] full17;
  logic [16:0] old_s;
  logic [17:0] diff;
  logic [17:0] mag;
  logic [18:0] twice;
  logic        wrap;
  logic [47:0] g_base;

  assign take  = q_valid_i && (!out_valid_q || out_ready_i);
  assign pop_o = take;

  // Nearest-wrap choice and global sweep update
  always_comb begin
    sb      = (sweep_bits_i > SweepMaxBits) ? SweepMaxBits : sweep_bits_i;
    full48  = 48'd1 << sb;
    full17  = 17'd1 << sb;
    is_new  = !have_q || (q_data_i.sweep != last_q);
    // previous counter reads as minus one before the first hit
    old_s   = have_q ? {1'b0, last_q} : {17{1'b1}};
    diff    = {2'b00, q_data_i.sweep} - {old_s[16], old_s};
    mag     = diff[17] ? (18'd0 - diff) : diff;
    twice   = {mag, 1'b0};
    wrap    = twice > {2'b00, full17};
    g_base  = (gsweep_q & ~(full48 - 48'd1)) | {32'd0, q_data_i.sweep};
    gsweep_d = gsweep_q;
    evcnt_d  = evcnt_q;
    if (is_new) begin
      evcnt_d = evcnt_q + 32'd1;
      if (wrap && !diff[17]) begin
        gsweep_d = g_base - full48;
      end else if (wrap) begin
        gsweep_d = g_base + full48;
      end else begin
        gsweep_d = g_base;
      end
    end
  end

  // Control and unwrap state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      last_q      <= '0;
      have_q      <= 1'b0;
      gsweep_q    <= '0;
      evcnt_q     <= '0;
    end else begin
      if (take) begin
        out_valid_q <= 1'b1;
        last_q      <= q_data_i.sweep;
        have_q      <= 1'b1;
        gsweep_q    <= gsweep_d;
        evcnt_q     <= evcnt_d;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Output payload register
  always_ff @(posedge clk_i) begin
    if (take) begin
      hit_channel_o  <= q_data_i.channel;
      hit_edge_o     <= q_data_i.edge_bit;
      time_value_o   <= q_data_i.time_val;
      sweep_local_o  <= q_data_i.sweep;
      global_sweep_o <= gsweep_d;
      hit_tag_o      <= q_data_i.tag;
      hit_lost_o     <= q_data_i.lost;
      new_event_o    <= is_new;
      event_number_o <= evcnt_d;
    end
  end

  assign out_valid_o = out_valid_q;

  // Checks
  a_repeat_keeps_sweep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    take && !is_new |=> $stable(gsweep_q) && $stable(evcnt_q))
    else $error("global sweep moved on a repeated sweep counter");

  a_new_counts_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    take && is_new |=> evcnt_q == $past(evcnt_q) + 32'd1)
    else $error("event counter did not step by one");

  a_take_sets_have: assert property (@(posedge clk_i) disable iff (!rst_ni)
    take |=> have_q && out_valid_q)
    else $error("hit taken without output or sweep history");

  a_first_is_new: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !have_q && take |=> new_event_o)
    else $error("first hit after reset did not start an event");

endmodule : tlwsu_back

`default_nettype wire

@@ verif/tb_tdc_list_word_sweep_unwrap.sv @@
// ----------------------------------------------------------------------------
// tb_tdc_list_word_sweep_unwrap
// Self-checking bench for the list-word splitter: predicts every kept hit
// (field split, channel filter, sweep unwrap, event count) from the word and
// the current register set, and compares each output beat against it while
// both handshakes idle at random, save in the last phase.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_tdc_list_word_sweep_unwrap;
  import tlwsu_pkg::*;

  localparam int unsigned WordsPerPhase = 272;
  localparam int unsigned NumSetups     = 6;

  // One predicted or observed output beat
  typedef struct {
    bit [2:0]  channel;
    bit        edge_bit;
    bit [47:0] time_val;
    bit [15:0] sweep;
    bit [47:0] gsweep;
    bit        tag;
    bit        lost;
    bit        new_event;
    bit [31:0] event_num;
  } hit_rec_t;

  // Hit predictor and queue of hits still owed by the block
  class hit_scoreboard;
    bit        filter_on;
    bit [2:0]  sel_channel;
    bit [5:0]  time_low;
    bit [5:0]  time_bits;
    bit [5:0]  sweep_low;
    bit [4:0]  sweep_bits;
    bit [5:0]  tag_low;
    bit [5:0]  lost_bit;

    bit [15:0] last_sweep;
    bit        primed;
    bit [47:0] gsweep;
    bit [31:0] event_count;

    hit_rec_t    pending[$];
    int unsigned errors;
    int unsigned hits_checked;

    function new();
      filter_on   = RstFilterOn;
      sel_channel = RstSelChan;
      time_low    = RstTimeLow;
      time_bits   = RstTimeBits;
      sweep_low   = RstSweepLow;
      sweep_bits  = RstSweepBits;
      tag_low     = RstTagLow;
      lost_bit    = RstLostBit;
    endfunction

    function bit [63:0] low_ones(int unsigned n);
      return (n >= 64) ? {64{1'b1}} : (64'd1 << n) - 64'd1;
    endfunction

    function void set_reg(cfg_idx_e idx, bit [5:0] v);
      case (idx)
        CFG_FILTER_ON:   filter_on   = v[0];
        CFG_SEL_CHANNEL: sel_channel = v[2:0];
        CFG_TIME_LOW:    time_low    = v;
        CFG_TIME_BITS:   time_bits   = v;
        CFG_SWEEP_LOW:   sweep_low   = v;
        CFG_SWEEP_BITS:  sweep_bits  = v[4:0];
        CFG_TAG_LOW:     tag_low     = v;
        CFG_LOST_BIT:    lost_bit    = v;
        default: ;
      endcase
    endfunction

    // Returns 1 when the word yields a hit (and queues the predicted beat)
    function bit note_word(bit [63:0] w);
      hit_rec_t      h;
      bit [63:0]     tfield;
      bit [63:0]     span;
      bit [63:0]     g;
      int unsigned   sb;
      longint        s;
      longint        prev;
      longint        f;
      if (w == '0) return 1'b0;
      h.channel = w[2:0];
      if (h.channel < ChanMin || h.channel > ChanStart) return 1'b0;
      if (filter_on && h.channel != sel_channel && h.channel != ChanStart) return 1'b0;

      h.edge_bit = w[3];
      tfield     = (w >> time_low) & low_ones(time_bits);
      h.time_val = tfield[47:0];
      sb         = (sweep_bits > SweepMaxBits) ? SweepMaxBits : sweep_bits;
      span       = 64'd1 << sb;
      h.sweep    = 16'((w >> sweep_low) & (span - 64'd1));
      h.tag      = w[tag_low];
      h.lost     = w[lost_bit];

      // new sweep: pick the nearest of previous, same or next round
      h.new_event = !primed || h.sweep != last_sweep;
      if (h.new_event) begin
        s    = h.sweep;
        prev = -1;
        if (primed) prev = last_sweep;
        f = span;
        g = ({16'd0, gsweep} & ~(span - 64'd1)) + 64'(h.sweep);
        if (s > prev) begin
          if (s - prev > f - s + prev) g -= span;
        end else if (prev - s > f - prev + s) begin
          g += span;
        end
        gsweep      = g[47:0];
        last_sweep  = h.sweep;
        primed      = 1'b1;
        event_count = event_count + 32'd1;
      end

      if (h.time_val == '0) h.tag = ~h.tag;
      h.gsweep    = gsweep;
      h.event_num = event_count;
      pending = {pending, h};
      return 1'b1;
    endfunction

    function void cmp_field(string name, bit [63:0] want, bit [63:0] seen);
      if (want != seen) begin
        $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, seen);
        errors++;
      end
    endfunction

    function void check_hit(hit_rec_t got);
      hit_rec_t want;
      hits_checked++;
      if (pending.size() == 0) begin
        $error("unexpected hit beat: channel %0d sweep 0x%0h", got.channel, got.sweep);
        errors++;
        return;
      end
      want = pending.pop_front();
      cmp_field("hit_channel",  want.channel,   got.channel);
      cmp_field("hit_edge",     want.edge_bit,  got.edge_bit);
      cmp_field("time_value",   want.time_val,  got.time_val);
      cmp_field("sweep_local",  want.sweep,     got.sweep);
      cmp_field("global_sweep", want.gsweep,    got.gsweep);
      cmp_field("hit_tag",      want.tag,       got.tag);
      cmp_field("hit_lost",     want.lost,      got.lost);
      cmp_field("new_event",    want.new_event, got.new_event);
      cmp_field("event_number", want.event_num, got.event_num);
    endfunction
  endclass

  // DUT signals
  logic                clk_i       = 1'b0;
  logic                rst_ni      = 1'b0;
  logic                cfg_we_i    = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx_i   = '0;
  logic [CfgDataW-1:0] cfg_wdata_i = '0;
  logic                in_valid_i  = 1'b0;
  logic                in_ready_o;
  logic [63:0]         raw_word_i  = '0;
  logic                out_valid_o;
  logic                out_ready_i = 1'b0;
  logic [2:0]          hit_channel_o;
  logic                hit_edge_o;
  logic [47:0]         time_value_o;
  logic [15:0]         sweep_local_o;
  logic signed [47:0]  global_sweep_o;
  logic                hit_tag_o;
  logic                hit_lost_o;
  logic                new_event_o;
  logic [31:0]         event_number_o;

  hit_scoreboard board = new();
  hit_rec_t      seen_hit;
  bit [15:0]     next_sweep;
  bit            calm;
  int unsigned   words_sent;
  int unsigned   kept_total;

  // Register sets in index order: filter, channel, time low/width,
  // sweep low/width, tag, lost. Covers out-of-range channels, zero and
  // oversized widths, and fields hanging off the top of the word.
  bit [5:0] plan [NumSetups][8] = '{
    '{6'd0, 6'd2, 6'd4,  6'd48, 6'd52, 6'd12, 6'd3,  6'd63},
    '{6'd1, 6'd6, 6'd8,  6'd1,  6'd40, 6'd1,  6'd0,  6'd1},
    '{6'd1, 6'd0, 6'd63, 6'd63, 6'd48, 6'd16, 6'd63, 6'd0},
    '{6'd0, 6'd7, 6'd0,  6'd0,  6'd63, 6'd63, 6'd62, 6'd5},
    '{6'd1, 6'd5, 6'd16, 6'd40, 6'd56, 6'd32, 6'd60, 6'd2},
    '{6'd0, 6'd3, 6'd20, 6'd36, 6'd4,  6'd4,  6'd49, 6'd50}
  };

  tdc_list_word_sweep_unwrap dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .raw_word_i     (raw_word_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .hit_channel_o  (hit_channel_o),
    .hit_edge_o     (hit_edge_o),
    .time_value_o   (time_value_o),
    .sweep_local_o  (sweep_local_o),
    .global_sweep_o (global_sweep_o),
    .hit_tag_o      (hit_tag_o),
    .hit_lost_o     (hit_lost_o),
    .new_event_o    (new_event_o),
    .event_number_o (event_number_o)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Word in the power-on field layout
  function automatic bit [63:0] dflt_word(bit [2:0] ch, bit edg, bit [35:0] tval,
                                          bit [6:0] sw, bit tag, bit lost, bit [14:0] top);
    return {top, tag, lost, sw, tval, edg, ch};
  endfunction

  // Random word laid out for the current registers: mostly kept channels and
  // a plausible sweep sequence, with wraps, half-range jumps and noise
  function automatic bit [63:0] gen_word();
    bit [63:0]   w;
    bit [63:0]   span;
    int unsigned sb;
    int unsigned roll;
    bit [2:0]    ch;
    w    = {$urandom, $urandom};
    roll = $urandom_range(0, 99);
    if (roll < 3) return '0;
    sb   = (board.sweep_bits > SweepMaxBits) ? SweepMaxBits : board.sweep_bits;
    span = 64'd1 << sb;
    roll = $urandom_range(0, 99);
    if (roll >= 90)      next_sweep = 16'($urandom);
    else if (roll >= 85) next_sweep = 16'(span - 64'd1);
    else if (roll >= 80) next_sweep += 16'(span >> 1);
    else if (roll >= 70) next_sweep -= 16'd1;
    else if (roll >= 40) next_sweep += 16'd1;
    if ($urandom_range(0, 7) == 0)
      w &= ~(board.low_ones(board.time_bits) << board.time_low);
    w &= ~((span - 64'd1) << board.sweep_low);
    w |= (64'(next_sweep) & (span - 64'd1)) << board.sweep_low;
    roll = $urandom_range(0, 99);
    if (roll < 45)      ch = board.sel_channel;
    else if (roll < 70) ch = ChanStart;
    else if (roll < 90) ch = 3'($urandom_range(1, 6));
    else                ch = 3'($urandom_range(0, 7));
    w[2:0] = ch;
    return w;
  endfunction

  // Offer one word and hold it until the beat is taken
  task automatic send_word(input bit [63:0] w);
    in_valid_i <= 1'b1;
    raw_word_i <= w;
    do @(posedge clk_i); while (!in_ready_o);
    words_sent++;
    if (board.note_word(w)) kept_total++;
  endtask

  // Stop sending and let every owed hit come out, plus pipeline slack
  task automatic drain();
    in_valid_i <= 1'b0;
    while (board.pending.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic apply_setup(input int p);
    for (int i = 0; i < 8; i++) begin
      cfg_we_i    <= 1'b1;
      cfg_idx_i   <= cfg_idx_e'(i);
      cfg_wdata_i <= plan[p][i];
      @(posedge clk_i);
      board.set_reg(cfg_idx_e'(i), plan[p][i]);
    end
    cfg_we_i <= 1'b0;
  endtask

  // Output side: random stall bursts, none once the run turns calm
  initial begin
    int unsigned n;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      n = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 20);
      out_ready_i <= 1'b1;
      repeat (n) @(posedge clk_i);
      if (!calm) begin
        out_ready_i <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk_i);
      end
    end
  end

  // Check every accepted output beat
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      seen_hit.channel   = hit_channel_o;
      seen_hit.edge_bit  = hit_edge_o;
      seen_hit.time_val  = time_value_o;
      seen_hit.sweep     = sweep_local_o;
      seen_hit.gsweep    = global_sweep_o;
      seen_hit.tag       = hit_tag_o;
      seen_hit.lost      = hit_lost_o;
      seen_hit.new_event = new_event_o;
      seen_hit.event_num = event_number_o;
      board.check_hit(seen_hit);
    end
  end

  initial begin
    int unsigned start;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed words on the power-on layout
    send_word(64'd0);
    send_word(64'h0000_0000_0000_0010);                           // channel 0
    send_word(dflt_word(3'd7, 1'b1, 36'h55, 7'd3, 1'b1, 1'b0, 15'h1));
    send_word(dflt_word(3'd2, 1'b0, 36'h77, 7'd9, 1'b0, 1'b1, 15'h0)); // filtered
    // first hit, high counter: lands in the previous round
    send_word(dflt_word(3'd1, 1'b0, 36'h123, 7'd100, 1'b0, 1'b0, 15'h0));
    // same sweep, zero time flips the tag
    send_word(dflt_word(3'd6, 1'b1, 36'h0, 7'd100, 1'b1, 1'b0, 15'h0));
    send_word(dflt_word(3'd1, 1'b1, 36'hF_FFFF_FFFF, 7'd101, 1'b0, 1'b1, 15'h7FFF));
    send_word(dflt_word(3'd6, 1'b0, 36'h5, 7'd127, 1'b0, 1'b0, 15'h2AAA));
    send_word(dflt_word(3'd1, 1'b0, 36'h9, 7'd0, 1'b1, 1'b1, 15'h1555)); // forward wrap
    send_word(dflt_word(3'd1, 1'b0, 36'h9, 7'd64, 1'b0, 1'b0, 15'h0));  // tie, up
    send_word(dflt_word(3'd6, 1'b0, 36'h9, 7'd0, 1'b0, 1'b0, 15'h0));   // tie, down
    send_word(dflt_word(3'd1, 1'b0, 36'h1, 7'd120, 1'b0, 1'b0, 15'h0)); // back wrap
    send_word(dflt_word(3'd1, 1'b1, 36'h1, 7'd5, 1'b1, 1'b0, 15'h0));
    send_word(64'hFFFF_FFFF_FFFF_FFFE);
    send_word(64'hFFFF_FFFF_FFFF_FFFF);
    send_word(dflt_word(3'd6, 1'b1, 36'h0, 7'd5, 1'b0, 1'b1, 15'h0));
    send_word(dflt_word(3'd5, 1'b1, 36'h3, 7'd6, 1'b0, 1'b0, 15'h0));
    send_word(64'h8000_0000_0000_0000);

    // Random phases, one per register set; the last runs without idling
    for (int p = 0; p <= NumSetups; p++) begin
      if (p > 0) begin
        drain();
        apply_setup(p - 1);
      end
      calm  = (p == NumSetups);
      start = words_sent;
      while (words_sent - start < WordsPerPhase) begin
        send_word(gen_word());
        if (!calm && (kept_total % 100) >= 40 && $urandom_range(0, 5) == 0) begin
          in_valid_i <= 1'b0;
          repeat ($urandom_range(1, 12)) @(posedge clk_i);
        end
      end
    end

    drain();
    $display("%0d words sent, %0d kept, over %0d register sets",
             words_sent, kept_total, NumSetups + 1);
    $display("%0d hit beats compared, %0d sweep events unwrapped",
             board.hits_checked, board.event_count);
    if (board.errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // Run limit
  initial begin
    #10_000_000;
    $display("simulation failed");
    $finish;
  end

endmodule

@@ tdc_list_word_sweep_unwrap.f @@
hw/rtl/tlwsu_pkg.sv
hw/rtl/tlwsu_front.sv
hw/rtl/tlwsu_queue.sv
hw/rtl/tlwsu_back.sv
hw/rtl/tdc_list_word_sweep_unwrap.sv
verif/tb_tdc_list_word_sweep_unwrap.sv
